// ===== rtl/core/cfp_pkg.sv =====
// Shared types, codes and helper functions for the camera pair core.
package cfp_pkg;

   // Pivot threshold register, unsigned Q15.16.
   localparam int THR_W = 31;
   localparam logic [THR_W-1:0] THR_RESET = 31'd1;

   // Row pairs of the transposed matrix tried for the 2x2 minor, in order.
   localparam logic [1:0] PAIR_01 = 2'd0;
   localparam logic [1:0] PAIR_02 = 2'd1;
   localparam logic [1:0] PAIR_12 = 2'd2;

   // What the front hands to the back along with the matrix and the minor.
   typedef struct packed {
      logic [1:0] pair;
      logic [1:0] piv;
      logic       no_pivot;
   } cfp_cls_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL_A,
      F_MUL_B,
      F_EVAL
   } cfp_front_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_ERR,
      B_NY0,
      B_NY1,
      B_NY2,
      B_DIVY,
      B_NX0,
      B_NX1,
      B_DIVX,
      B_EL0,
      B_EL1,
      B_EL2,
      B_COL3
   } cfp_back_state_type;

   function automatic logic [1:0] pair_lo(logic [1:0] pair);
      logic [1:0] r;
      unique case (pair)
         PAIR_01: r = 2'd0;
         PAIR_02: r = 2'd0;
         default: r = 2'd1;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] pair_hi(logic [1:0] pair);
      logic [1:0] r;
      unique case (pair)
         PAIR_01: r = 2'd1;
         default: r = 2'd2;
      endcase
      return r;
   endfunction

   // Flat position of F[r][c] in the row-major matrix.
   function automatic logic [3:0] fidx(logic [1:0] r, logic [1:0] c);
      return {2'b00, r} * 4'd3 + {2'b00, c};
   endfunction

endpackage

// ===== rtl/core/cfp_queue.sv =====
// Two-entry queue between the classifying front and the computing back.
module cfp_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/cfp_front.sv =====
// Front end: takes a matrix, finds the pivot minor and leading entry, queues the work.
module cfp_front #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [9*DATA_WIDTH-1:0]       in_mat,
   input  logic [cfp_pkg::THR_W-1:0]     thr,
   output logic                          push,
   input  logic                          full,
   output logic [9*DATA_WIDTH-1:0]       out_mat,
   output logic signed [2*DATA_WIDTH:0]  out_det,
   output cfp_pkg::cfp_cls_type          out_cls
);
   import cfp_pkg::*;

   localparam int DW  = DATA_WIDTH;
   localparam int CW  = (2*DW+1 > THR_W+FRAC_BITS) ? 2*DW+1 : THR_W+FRAC_BITS;
   localparam int PCW = (DW+1 > THR_W) ? DW+1 : THR_W;

   cfp_front_state_type         st_ff, st_in;
   logic [8:0][DW-1:0]          mat_ff, mat_in;
   logic [1:0]                  pair_ff, pair_in;
   logic signed [2*DW-1:0]      prod_ff, hold_ff;
   logic signed [DW-1:0]        ma, mb;
   logic                        mul_en;
   logic signed [2*DW:0]        det;
   logic [2*DW:0]               det_mag;
   logic                        det_ok;
   logic [2:0]                  ent_ok;
   logic [1:0]                  piv;
   logic                        piv_found;
   logic                        done;

   assign det     = (2*DW+1)'(hold_ff) - (2*DW+1)'(prod_ff);
   assign det_mag = det[2*DW] ? (~det + 1'b1) : det;
   assign det_ok  = CW'(det_mag) > CW'({thr, {FRAC_BITS{1'b0}}});

   // Leading entries of the transposed matrix are the first row of F.
   always_comb begin
      logic [DW-1:0] f;
      logic [DW:0]   mag;
      for (int k = 0; k < 3; k++) begin
         f         = mat_ff[k];
         mag       = {1'b0, (f[DW-1] ? (~f + 1'b1) : f)};
         ent_ok[k] = PCW'(mag) > PCW'(thr);
      end
   end

   always_comb begin
      piv_found = 1'b1;
      priority if (ent_ok[0]) begin
         piv = 2'd0;
      end else if (ent_ok[1]) begin
         piv = 2'd1;
      end else if (ent_ok[2]) begin
         piv = 2'd2;
      end else begin
         piv       = 2'd0;
         piv_found = 1'b0;
      end
   end

   assign done     = (st_ff == F_EVAL) && (det_ok || pair_ff == PAIR_12);
   assign push     = done && !full;
   assign in_ready = (st_ff == F_IDLE) || push;

   assign out_mat          = mat_ff;
   assign out_det          = det;
   assign out_cls.pair     = pair_ff;
   assign out_cls.piv      = piv;
   assign out_cls.no_pivot = !det_ok || !piv_found;

   always_comb begin
      st_in   = st_ff;
      mat_in  = mat_ff;
      pair_in = pair_ff;
      mul_en  = 1'b0;
      ma      = $signed(mat_ff[fidx(2'd0, pair_lo(pair_ff))]);
      mb      = $signed(mat_ff[fidx(2'd1, pair_hi(pair_ff))]);
      unique case (st_ff)
         F_IDLE: begin
         end
         F_MUL_A: begin
            mul_en = 1'b1;
            st_in  = F_MUL_B;
         end
         F_MUL_B: begin
            mul_en = 1'b1;
            ma     = $signed(mat_ff[fidx(2'd1, pair_lo(pair_ff))]);
            mb     = $signed(mat_ff[fidx(2'd0, pair_hi(pair_ff))]);
            st_in  = F_EVAL;
         end
         F_EVAL: begin
            if (push) begin
               st_in = F_IDLE;
            end else if (!done) begin
               pair_in = pair_ff + 2'd1;
               st_in   = F_MUL_A;
            end
         end
      endcase
      if (in_valid && in_ready) begin
         mat_in  = in_mat;
         pair_in = PAIR_01;
         st_in   = F_MUL_A;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= F_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      mat_ff  <= mat_in;
      pair_ff <= pair_in;
      if (mul_en) begin
         prod_ff <= ma * mb;
         hold_ff <= prod_ff;
      end
   end

endmodule

// ===== rtl/core/cfp_div.sv =====
// Restoring divider, one quotient bit per cycle, with an overflow flag for saturation.
module cfp_div #(
   parameter int QW   = 32,
   parameter int NW   = 98,
   parameter int DENW = 82
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [NW-1:0]   num,
   input  logic [DENW-1:0] den,
   output logic            done,
   output logic [QW-1:0]   quo,
   output logic            ovf
);
   localparam int XW   = NW + QW + DENW + 1;
   localparam int CNTW = $clog2(QW+1);

   logic [XW-1:0]   rem_ff, dsh_ff;
   logic [QW-1:0]   q_ff;
   logic            ovf_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            run_ff, done_ff;
   logic            ge;

   assign ge   = rem_ff >= dsh_ff;
   assign done = done_ff;
   assign quo  = q_ff;
   assign ovf  = ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= run_ff && cnt_ff == CNTW'(1);
         if (start) begin
            run_ff <= 1'b1;
         end else if (cnt_ff == CNTW'(1)) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= XW'(num);
         dsh_ff <= XW'(den) << (QW-1);
         ovf_ff <= XW'(num) >= (XW'(den) << QW);
         q_ff   <= '0;
         cnt_ff <= CNTW'(QW);
      end else if (run_ff) begin
         if (ge) begin
            rem_ff <= rem_ff - dsh_ff;
         end
         q_ff   <= {q_ff[QW-2:0], ge};
         dsh_ff <= dsh_ff >> 1;
         cnt_ff <= cnt_ff - CNTW'(1);
      end
   end

endmodule

// ===== rtl/core/cfp_back.sv =====
// Back end: gets the epipole, emits twelve second-camera elements or a no-pivot beat.
module cfp_back #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   output logic                          q_pop,
   input  logic [9*DATA_WIDTH-1:0]       q_mat,
   input  logic signed [2*DATA_WIDTH:0]  q_det,
   input  cfp_pkg::cfp_cls_type          q_cls,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [1:0]                    out_row,
   output logic [1:0]                    out_col,
   output logic signed [DATA_WIDTH-1:0]  out_value,
   output logic                          out_no_pivot,
   output logic                          out_last
);
   import cfp_pkg::*;

   localparam int DW = DATA_WIDTH;
   localparam int FB = FRAC_BITS;
   localparam int SW = 2*DW + FB + 2;
   localparam int NW = SW + FB;
   localparam int RW = SW - FB + 1;
   localparam logic [DW-1:0] MIN_V = {1'b1, {(DW-1){1'b0}}};
   localparam logic [DW-1:0] MAX_V = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] NEG_ONE =
      (FB >= DW-1) ? MIN_V : (~(DW'(1) << FB) + DW'(1));

   cfp_back_state_type     st_ff, st_in;
   logic [8:0][DW-1:0]     mat_ff, mat_in;
   logic signed [2*DW:0]   det_ff, det_in;
   cfp_cls_type            cls_ff, cls_in;
   logic signed [2*DW-1:0] prod_ff;
   logic signed [SW-1:0]   acc_ff, acc_in;
   logic signed [DW-1:0]   y_ff, y_in, x_ff, x_in;
   logic [3:0]             idx_ff, idx_in;
   logic                   neg_ff, neg_in;
   logic                   valid_ff;
   logic [1:0]             row_ff, col_ff;
   logic [DW-1:0]          val_ff;
   logic                   nopiv_ff, last_ff;

   logic signed [DW-1:0]   ma, mb;
   logic                   mul_en;
   logic                   div_start, div_done, div_ovf;
   logic [NW-1:0]          div_num;
   logic [SW-1:0]          div_den;
   logic [DW-1:0]          div_q;
   logic                   out_free, emit;
   logic [1:0]             e_row, e_col;
   logic [DW-1:0]          e_val;
   logic                   e_nopiv, e_last;

   logic [1:0]             ra, rb, pv, row, col;
   logic signed [SW-1:0]   prod_x, ny, nx, sum, f0c_sh, f1c_sh, f2p_sh;
   logic signed [DW-1:0]   f0p;

   function automatic logic [SW-1:0] abs_sw(logic signed [SW-1:0] v);
      return v[SW-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [DW-1:0] div_sat(logic neg, logic ovf, logic [DW-1:0] q);
      logic [DW-1:0] r;
      if (neg) begin
         r = (ovf || q > MIN_V) ? MIN_V : (~q + 1'b1);
      end else begin
         r = (ovf || q[DW-1]) ? MAX_V : q;
      end
      return r;
   endfunction

   // Q32.32 down to Q16.16, nearest with ties away from zero, then saturated.
   function automatic logic [DW-1:0] round_sat(logic signed [SW-1:0] v);
      logic [SW-1:0] mag;
      logic [SW:0]   rs;
      logic [RW-1:0] r;
      logic [DW-1:0] res;
      mag = abs_sw(v);
      rs  = {1'b0, mag} + ((SW+1)'(1) << (FB-1));
      r   = rs[SW:FB];
      if (v[SW-1]) begin
         res = (r > RW'(MIN_V)) ? MIN_V : (~r[DW-1:0] + 1'b1);
      end else begin
         res = (r >= RW'(MIN_V)) ? MAX_V : r[DW-1:0];
      end
      return res;
   endfunction

   function automatic logic [DW-1:0] neg_sat(logic [DW-1:0] v);
      return (v == MIN_V) ? MAX_V : (~v + 1'b1);
   endfunction

   assign ra  = pair_lo(cls_ff.pair);
   assign rb  = pair_hi(cls_ff.pair);
   assign pv  = cls_ff.piv;
   assign row = idx_ff[3:2];
   assign col = idx_ff[1:0];

   assign prod_x = SW'(prod_ff);
   assign ny     = acc_ff - prod_x;
   assign f0p    = $signed(mat_ff[fidx(2'd0, pv)]);
   assign f2p_sh = SW'($signed(mat_ff[fidx(2'd2, pv)])) <<< FB;
   assign nx     = -prod_x - f2p_sh;
   assign f0c_sh = SW'($signed(mat_ff[fidx(2'd0, col)])) <<< FB;
   assign f1c_sh = SW'($signed(mat_ff[fidx(2'd1, col)])) <<< FB;
   assign sum    = acc_ff + prod_x;

   assign out_free = !valid_ff || out_ready;

   always_comb begin
      st_in     = st_ff;
      mat_in    = mat_ff;
      det_in    = det_ff;
      cls_in    = cls_ff;
      acc_in    = acc_ff;
      y_in      = y_ff;
      x_in      = x_ff;
      idx_in    = idx_ff;
      neg_in    = neg_ff;
      q_pop     = 1'b0;
      mul_en    = 1'b0;
      ma        = '0;
      mb        = '0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      emit      = 1'b0;
      e_row     = row;
      e_col     = col;
      e_val     = '0;
      e_nopiv   = 1'b0;
      e_last    = 1'b0;
      unique case (st_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               mat_in = q_mat;
               det_in = q_det;
               cls_in = q_cls;
               st_in  = q_cls.no_pivot ? B_ERR : B_NY0;
            end
         end
         B_ERR: begin
            if (out_free) begin
               emit    = 1'b1;
               e_row   = 2'd0;
               e_col   = 2'd0;
               e_nopiv = 1'b1;
               e_last  = 1'b1;
               st_in   = B_IDLE;
            end
         end
         B_NY0: begin
            mul_en = 1'b1;
            ma     = $signed(mat_ff[fidx(2'd2, ra)]);
            mb     = $signed(mat_ff[fidx(2'd0, rb)]);
            st_in  = B_NY1;
         end
         B_NY1: begin
            acc_in = prod_x;
            mul_en = 1'b1;
            ma     = $signed(mat_ff[fidx(2'd0, ra)]);
            mb     = $signed(mat_ff[fidx(2'd2, rb)]);
            st_in  = B_NY2;
         end
         B_NY2: begin
            div_start = 1'b1;
            div_num   = NW'(abs_sw(ny)) << FB;
            div_den   = abs_sw(SW'(det_ff));
            neg_in    = ny[SW-1] ^ det_ff[2*DW];
            st_in     = B_DIVY;
         end
         B_DIVY: begin
            if (div_done) begin
               y_in  = div_sat(neg_ff, div_ovf, div_q);
               st_in = B_NX0;
            end
         end
         B_NX0: begin
            mul_en = 1'b1;
            ma     = $signed(mat_ff[fidx(2'd1, pv)]);
            mb     = y_ff;
            st_in  = B_NX1;
         end
         B_NX1: begin
            div_start = 1'b1;
            div_num   = NW'(abs_sw(nx));
            div_den   = abs_sw(SW'(f0p));
            neg_in    = nx[SW-1] ^ f0p[DW-1];
            st_in     = B_DIVX;
         end
         B_DIVX: begin
            if (div_done) begin
               x_in   = div_sat(neg_ff, div_ovf, div_q);
               idx_in = 4'd0;
               st_in  = B_EL0;
            end
         end
         B_EL0: begin
            // First product: y*F2c for row 0, x*F2c for row 1, y*F0c for row 2.
            mul_en = 1'b1;
            ma     = (row == 2'd1) ? x_ff : y_ff;
            mb     = $signed(mat_ff[fidx((row == 2'd2) ? 2'd0 : 2'd2, col)]);
            st_in  = B_EL1;
         end
         B_EL1: begin
            unique case (row)
               2'd0:    acc_in = prod_x - f1c_sh;
               2'd1:    acc_in = f0c_sh - prod_x;
               default: acc_in = -prod_x;
            endcase
            // Only the last row has a second product, x*F1c.
            mul_en = 1'b1;
            if (row == 2'd2) begin
               ma = x_ff;
               mb = $signed(mat_ff[fidx(2'd1, col)]);
            end
            st_in = B_EL2;
         end
         B_EL2: begin
            if (out_free) begin
               emit   = 1'b1;
               e_val  = round_sat(sum);
               idx_in = idx_ff + 4'd1;
               st_in  = (col == 2'd2) ? B_COL3 : B_EL0;
            end
         end
         B_COL3: begin
            if (out_free) begin
               emit = 1'b1;
               unique case (row)
                  2'd0:    e_val = neg_sat(x_ff);
                  2'd1:    e_val = neg_sat(y_ff);
                  default: e_val = NEG_ONE;
               endcase
               if (row == 2'd2) begin
                  e_last = 1'b1;
                  st_in  = B_IDLE;
               end else begin
                  idx_in = idx_ff + 4'd1;
                  st_in  = B_EL0;
               end
            end
         end
         default: begin
            st_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (emit) begin
            valid_ff <= 1'b1;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      mat_ff <= mat_in;
      det_ff <= det_in;
      cls_ff <= cls_in;
      acc_ff <= acc_in;
      y_ff   <= y_in;
      x_ff   <= x_in;
      idx_ff <= idx_in;
      neg_ff <= neg_in;
      if (mul_en) begin
         prod_ff <= ma * mb;
      end
      if (emit) begin
         row_ff   <= e_row;
         col_ff   <= e_col;
         val_ff   <= e_val;
         nopiv_ff <= e_nopiv;
         last_ff  <= e_last;
      end
   end

   cfp_div #(
      .QW   (DW),
      .NW   (NW),
      .DENW (SW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_q),
      .ovf   (div_ovf)
   );

   assign out_valid    = valid_ff;
   assign out_row      = row_ff;
   assign out_col      = col_ff;
   assign out_value    = $signed(val_ff);
   assign out_no_pivot = nopiv_ff;
   assign out_last     = last_ff;

endmodule

// ===== rtl/core/camera_pair_from_fundamental_core.sv =====
// Top level of the core that derives the second canonical camera from a fundamental matrix.
//
// req_*: one beat carries a whole 3x3 matrix F, nine signed fixed-point entries, row-major.
// rsp_*: each matrix yields twelve beats, the elements of P2 = [skew(e') * F | -e'] in
//   row-major order, the last one flagged by rsp_tlast. When no usable pivot exists the
//   matrix yields one beat with rsp_tuser set, value zero and rsp_tlast set instead.
// csr_*: writes the pivot threshold; reset value is one LSB. Write it only while idle.
//
// The front works out the pivot minor with one multiplier, trying the row pairs in turn,
// and then hands the matrix to a two-entry queue. The back runs two serial divisions,
// then works out each element of columns 0 to 2 in B_EL0, B_EL1 and B_EL2 on one shared
// multiplier and each element of column 3 in B_COL3. A matrix with no pivot yields its
// one beat from B_ERR. The front takes the next matrix while the back is still busy.
// A stalled rsp_tready holds the output register; the back waits and the front and
// queue keep filling. Reset empties the queue and the output register and restores the
// threshold.
module camera_pair_from_fundamental_core #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // f_r0c0, f_r0c1, f_r0c2, f_r1c0, f_r1c1, f_r1c2, f_r2c0, f_r2c1, f_r2c2
   input  logic [((9*DATA_WIDTH+7)/8)*8-1:0]     req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // out_row, out_col, element_value
   output logic [((DATA_WIDTH+4+7)/8)*8-1:0]     rsp_tdata,
   // no_pivot
   output logic [0:0]                            rsp_tuser,
   output logic                                  rsp_tlast,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [cfp_pkg::THR_W-1:0]             csr_data
);
   import cfp_pkg::*;

   localparam int DW    = DATA_WIDTH;
   localparam int RSP_W = ((DW+4+7)/8)*8;
   localparam int QW    = 9*DW + 2*DW + 1 + $bits(cfp_cls_type);

   logic [THR_W-1:0]     thr_ff;
   logic                 push, full, pop, empty;
   logic [9*DW-1:0]      f_mat, b_mat;
   logic signed [2*DW:0] f_det, b_det;
   cfp_cls_type          f_cls, b_cls;
   logic [QW-1:0]        q_out;
   logic [1:0]           o_row, o_col;
   logic signed [DW-1:0] o_val;
   logic                 o_nopiv;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   cfp_front #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_mat   (req_tdata[9*DW-1:0]),
      .thr      (thr_ff),
      .push     (push),
      .full     (full),
      .out_mat  (f_mat),
      .out_det  (f_det),
      .out_cls  (f_cls)
   );

   cfp_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({f_cls, f_det, f_mat}),
      .full      (full),
      .pop       (pop),
      .pop_data  (q_out),
      .empty     (empty)
   );

   assign b_mat = q_out[9*DW-1:0];
   assign b_det = $signed(q_out[11*DW:9*DW]);
   assign b_cls = q_out[QW-1:11*DW+1];

   cfp_back #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (empty),
      .q_pop        (pop),
      .q_mat        (b_mat),
      .q_det        (b_det),
      .q_cls        (b_cls),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_row      (o_row),
      .out_col      (o_col),
      .out_value    (o_val),
      .out_no_pivot (o_nopiv),
      .out_last     (rsp_tlast)
   );

   assign rsp_tdata    = RSP_W'({o_val, o_col, o_row});
   assign rsp_tuser[0] = o_nopiv;

endmodule

// ===== rtl/core/cfp_checker.sv =====
// Port-level checks for the camera pair core, bound to its top level.
module cfp_port_checker #(
   parameter int DATA_WIDTH = 32
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [((DATA_WIDTH+4+7)/8)*8-1:0] rsp_tdata,
   input logic [0:0]                        rsp_tuser,
   input logic                              rsp_tlast
);
   // A stalled result beat stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // A no-pivot beat is flagged last and carries zeros.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast && rsp_tdata[DATA_WIDTH+3:0] == '0)
      else $error("no-pivot beat malformed");

   // A regular run ends on row 2, column 3.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast && !rsp_tuser[0] |-> rsp_tdata[1:0] == 2'd2
         && rsp_tdata[3:2] == 2'd3)
      else $error("run ended on the wrong element");

   // Row index never reaches 3.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3)
      else $error("row index out of range");

endmodule

bind camera_pair_from_fundamental_core cfp_port_checker #(
   .DATA_WIDTH (DATA_WIDTH)
) u_cfp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== tb/sv/cfp_checker.sv =====
// Checker for the camera pair core: predicts P2 beats per matrix and compares them.
`timescale 1ns / 100ps

module cfp_checker #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [((9*DATA_WIDTH+7)/8)*8-1:0] req_tdata,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [((DATA_WIDTH+4+7)/8)*8-1:0] rsp_tdata,
   input  logic [0:0]                        rsp_tuser,
   input  logic                              rsp_tlast,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [cfp_pkg::THR_W-1:0]         csr_data,
   output int                                errors,
   output int                                pending
);

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic [1:0]            row;
      logic [1:0]            col;
      logic [DATA_WIDTH-1:0] value;
      logic                  no_pivot;
      logic                  last;
   } p2_beat_type;

   p2_beat_type               p2_expected[$];
   logic [cfp_pkg::THR_W-1:0] threshold;

   assign pending = p2_expected.size();

   function automatic wide_type clamp_data(wide_type v);
      wide_type hi;
      wide_type lo;
      hi = (wide_type'(1) <<< (DATA_WIDTH - 1)) - 1;
      lo = -(wide_type'(1) <<< (DATA_WIDTH - 1));
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic wide_type abs_w(wide_type v);
      return (v < 0) ? -v : v;
   endfunction

   // Quotient of magnitudes, truncated, signed by the operand signs, then saturated.
   function automatic wide_type signed_quot(wide_type num_mag, logic num_neg, wide_type den);
      wide_type q;
      q = num_mag / abs_w(den);
      return clamp_data((num_neg != (den < 0)) ? -q : q);
   endfunction

   // Q32.32 to Q16.16, nearest with ties away from zero, saturated.
   function automatic wide_type round_q(wide_type acc);
      wide_type m;
      m = (abs_w(acc) + (wide_type'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      return clamp_data((acc < 0) ? -m : m);
   endfunction

   task automatic predict_p2(input logic [((9*DATA_WIDTH+7)/8)*8-1:0] d);
      wide_type    f[3][3];
      wide_type    sk[3][3];
      wide_type    e[3];
      wide_type    thr;
      wide_type    minor;
      wide_type    ny;
      wide_type    nx;
      wide_type    acc;
      int          ra;
      int          rb;
      int          piv;
      int          i;
      int          j;
      p2_beat_type b;
      ra  = -1;
      rb  = -1;
      piv = -1;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            f[r][c] = $signed(d[(r*3+c)*DATA_WIDTH +: DATA_WIDTH]);
      thr = wide_type'({97'b0, threshold});
      // Rows of F transposed are columns of F; pairs tried in the order 01, 02, 12.
      for (int k = 0; k < 3 && ra < 0; k++) begin
         i = (k == 2) ? 1 : 0;
         j = (k == 0) ? 1 : 2;
         minor = f[0][i] * f[1][j] - f[1][i] * f[0][j];
         if (abs_w(minor) > (thr <<< FRAC_BITS)) begin
            ra = i;
            rb = j;
            e[1] = minor;
         end
      end
      for (int k = 0; k < 3 && ra >= 0 && piv < 0; k++)
         if (abs_w(f[0][k]) > thr) piv = k;
      if (ra < 0 || piv < 0) begin
         b = '{2'd0, 2'd0, '0, 1'b1, 1'b1};
         p2_expected.push_back(b);
         return;
      end
      minor = e[1];
      ny = f[2][ra] * f[0][rb] - f[0][ra] * f[2][rb];
      e[1] = signed_quot(abs_w(ny) <<< FRAC_BITS, ny < 0, minor);
      nx = -(f[1][piv] * e[1]) - (f[2][piv] <<< FRAC_BITS);
      e[0] = signed_quot(abs_w(nx), nx < 0, f[0][piv]);
      e[2] = wide_type'(1) <<< FRAC_BITS;
      sk[0][0] = 0;     sk[0][1] = -e[2]; sk[0][2] = e[1];
      sk[1][0] = e[2];  sk[1][1] = 0;     sk[1][2] = -e[0];
      sk[2][0] = -e[1]; sk[2][1] = e[0];  sk[2][2] = 0;
      for (int n = 0; n < 12; n++) begin
         b.row      = 2'(n / 4);
         b.col      = 2'(n % 4);
         b.no_pivot = 1'b0;
         b.last     = (n == 11);
         if (n % 4 < 3) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += sk[n/4][k] * f[k][n%4];
            b.value = DATA_WIDTH'(round_q(acc));
         end else begin
            b.value = DATA_WIDTH'(clamp_data(-e[n/4]));
         end
         p2_expected.push_back(b);
      end
   endtask

   task automatic report(input string what, input longint got, input longint want);
      if (errors < 40)
         $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      p2_beat_type b;
      if (reset) begin
         threshold <= cfp_pkg::THR_RESET;
         errors    <= 0;
      end else begin
         if (csr_valid && csr_ready) threshold <= csr_data;
         if (req_tvalid && req_tready) predict_p2(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (p2_expected.size() == 0) begin
               report("unexpected beat, tdata", rsp_tdata, 0);
            end else begin
               b = p2_expected.pop_front();
               if (rsp_tdata[1:0] !== b.row) report("out_row", rsp_tdata[1:0], b.row);
               if (rsp_tdata[3:2] !== b.col) report("out_col", rsp_tdata[3:2], b.col);
               if (rsp_tdata[4 +: DATA_WIDTH] !== b.value)
                  report("element_value", rsp_tdata[4 +: DATA_WIDTH], b.value);
               if (rsp_tuser[0] !== b.no_pivot) report("no_pivot", rsp_tuser[0], b.no_pivot);
               if (rsp_tlast !== b.last) report("last_of_run", rsp_tlast, b.last);
            end
         end
      end
   end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the camera pair core: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb;

   localparam int DW        = 32;
   localparam int REQ_W     = ((9*DW+7)/8)*8;
   localparam int RSP_W     = ((DW+4+7)/8)*8;
   localparam int IDLE_MAX  = 6000;
   localparam int Q1        = 32'h0001_0000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_W-1:0]          req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_W-1:0]          rsp_tdata;
   logic [0:0]                rsp_tuser;
   logic                      rsp_tlast;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [cfp_pkg::THR_W-1:0] csr_data = '0;
   int                        errors;
   int                        pending;
   int                        burst_left = 0;
   int                        stall_left = 0;
   int                        idle_cycles = 0;

   always #1 clock = ~clock;

   camera_pair_from_fundamental_core u_top (.*);

   cfp_checker u_checker (.*);

   // Receiver: runs of ready and runs of stall of random length, sometimes long.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= ~rsp_tready;
         stall_left <= rsp_tready ? $urandom_range(0, ($urandom_range(0, 3) == 0) ? 20 : 2)
                                  : $urandom_range(0, 40);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_MAX) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_matrix(input logic [DW-1:0] m[9]);
      logic [REQ_W-1:0] d;
      d = '0;
      for (int k = 0; k < 9; k++) d[k*DW +: DW] = m[k];
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 8);
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 150)) @(posedge clock);
         end
      end
   endtask

   task automatic write_threshold(input logic [cfp_pkg::THR_W-1:0] v);
      // Drop the request first so the last beat is not taken twice, and let the
      // checker see that beat before waiting for the pipeline to drain.
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [DW-1:0] rand_entry();
      case ($urandom_range(0, 9))
         0, 1:    return '0;
         2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         3, 4:    return $urandom();
         5:       return 32'($signed($urandom_range(0, 8)) - 4);
         default: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      endcase
   endfunction

   task automatic send_random(input int count);
      logic [DW-1:0] m[9];
      for (int n = 0; n < count; n++) begin
         for (int k = 0; k < 9; k++) m[k] = rand_entry();
         send_matrix(m);
      end
   endtask

   initial begin
      logic [DW-1:0] m[9];
      logic [cfp_pkg::THR_W-1:0] thr_list[5];
      thr_list = '{31'd0, 31'h7FFF_FFFF, 31'(Q1), 31'($urandom_range(2, 5000)), 31'd1};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero matrix: no pivot at all.
      m = '{default: '0};
      send_matrix(m);
      m = '{Q1, 0, 0, 0, Q1, 0, 0, 0, Q1};
      send_matrix(m);
      // Skew-symmetric, rank two.
      m = '{0, -Q1, Q1/2, Q1, 0, -(Q1*3/10), -(Q1/2), Q1*3/10, 0};
      send_matrix(m);
      m = '{default: 32'h7FFF_FFFF};
      send_matrix(m);
      m = '{default: 32'h8000_0000};
      send_matrix(m);
      m = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
      send_matrix(m);
      // First minor zero, second one chosen.
      m = '{Q1, Q1/2, 0, 0, 0, 2*Q1, 5*Q1, -3*Q1, Q1/3};
      send_matrix(m);
      // Only the last row pair qualifies, pivot in the second row.
      m = '{0, Q1, 0, 0, 0, Q1, 7*Q1, -Q1/5, 3*Q1};
      send_matrix(m);
      // Leading entries zero but the third, so the pivot is the last row.
      m = '{0, 0, 2*Q1, Q1, 3*Q1, 0, -Q1, Q1/7, 4*Q1};
      send_matrix(m);
      // Minor qualifies but no leading entry exceeds the threshold.
      m = '{1, 1, 1, 0, 32'h7FFF_FFFF, 5, 9*Q1, -Q1, 2};
      send_matrix(m);
      // Minor exactly at the threshold, then above it by raising one entry one step.
      m = '{256, 0, 0, 0, 256, 0, Q1, Q1, Q1};
      send_matrix(m);
      m = '{257, 0, 0, 0, 256, 0, Q1, Q1, Q1};
      send_matrix(m);
      send_random(4);

      foreach (thr_list[t]) begin
         write_threshold(thr_list[t]);
         m = '{1, 0, 0, 0, 1, 0, 3, -5, 7};
         send_matrix(m);
         send_random(18);
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (300) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
